/* hdl/ifr_pkg.sv */
package ifr_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned SEQ_BIT   = 6;
  localparam int unsigned REPLY_BIT = 7;

  localparam logic [BYTE_W-1:0] FLAG_RESET    = 8'h7E;
  localparam logic [BYTE_W-1:0] ESCAPE_RESET  = 8'h7D;
  localparam logic [BYTE_W-1:0] ADDRESS_RESET = 8'h03;

  localparam logic [BYTE_W-1:0] CTRL_INFO0 = 8'h00;
  localparam logic [BYTE_W-1:0] CTRL_INFO1 = 8'h40;
  localparam logic [BYTE_W-1:0] CTRL_RR    = 8'h05;
  localparam logic [BYTE_W-1:0] CTRL_REJ   = 8'h01;
  localparam logic [BYTE_W-1:0] ESC_XOR    = 8'h20;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_ADDR,
    PH_CTRL,
    PH_BCC1,
    PH_INFO
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FLAG,
    CFG_ESCAPE,
    CFG_ADDRESS
  } cfg_reg_e;

  typedef enum logic {
    KIND_PAYLOAD,
    KIND_VERDICT
  } kind_e;

  typedef enum logic [1:0] {
    VERDICT_NONE,
    VERDICT_ACCEPT,
    VERDICT_DUP,
    VERDICT_REJECT
  } verdict_e;

  typedef struct packed {
    logic [BYTE_W-1:0] flag;
    logic [BYTE_W-1:0] escape;
    logic [BYTE_W-1:0] address;
  } cfg_t;

  typedef struct packed {
    phase_e            phase;
    logic              exp_seq;
    logic              frame_seq;
    logic [BYTE_W-1:0] check;
    logic [BYTE_W-1:0] held;
    logic              held_vld;
    logic              esc_pend;
  } state_t;

  typedef struct packed {
    kind_e             kind;
    logic [BYTE_W-1:0] data;
    verdict_e          verdict;
  } result_t;

endpackage

/* hdl/ifr_if.sv */
interface ifr_byte_if;
  logic                       valid;
  logic                       ready;
  logic [ifr_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ifr_result_if;
  logic                       valid;
  logic                       ready;
  logic                       out_kind;
  logic [ifr_pkg::BYTE_W-1:0] out_byte;
  logic [1:0]                 verdict;

  modport source (output valid, output out_kind, output out_byte, output verdict, input ready);
  modport sink (input valid, input out_kind, input out_byte, input verdict, output ready);
endinterface

/* hdl/ifr_parser.sv */
module ifr_parser (
  input  ifr_pkg::cfg_t               cfg_i,
  input  ifr_pkg::state_t             st_i,
  input  logic [ifr_pkg::BYTE_W-1:0]  byte_i,
  output ifr_pkg::state_t             st_o,
  output logic                        res_vld_o,
  output ifr_pkg::result_t            res_o
);

  logic [ifr_pkg::BYTE_W-1:0] data;
  logic [ifr_pkg::BYTE_W-1:0] bcc1;
  logic                       take;
  logic                       nseq;
  logic                       chk_ok;
  logic                       seq_ok;

  assign nseq   = ~st_i.frame_seq;
  assign bcc1   = (st_i.frame_seq ? ifr_pkg::CTRL_INFO1 : ifr_pkg::CTRL_INFO0) ^ cfg_i.address;
  assign chk_ok = st_i.held_vld && !st_i.esc_pend && st_i.check == st_i.held;
  assign seq_ok = st_i.frame_seq == st_i.exp_seq;
  assign data   = st_i.esc_pend ? (byte_i ^ ifr_pkg::ESC_XOR) : byte_i;
  assign take   = byte_i != cfg_i.flag && (st_i.esc_pend || byte_i != cfg_i.escape);

  always_comb begin
    st_o = st_i;
    case (st_i.phase)
      ifr_pkg::PH_HUNT: begin
        if (byte_i == cfg_i.flag) st_o.phase = ifr_pkg::PH_ADDR;
      end
      ifr_pkg::PH_ADDR: begin
        if (byte_i == cfg_i.address) st_o.phase = ifr_pkg::PH_CTRL;
        else if (byte_i == cfg_i.flag) st_o.phase = ifr_pkg::PH_ADDR;
        else st_o.phase = ifr_pkg::PH_HUNT;
      end
      ifr_pkg::PH_CTRL: begin
        if (byte_i == ifr_pkg::CTRL_INFO0 || byte_i == ifr_pkg::CTRL_INFO1) begin
          st_o.frame_seq = byte_i[ifr_pkg::SEQ_BIT];
          st_o.phase     = ifr_pkg::PH_BCC1;
        end else if (byte_i == cfg_i.flag) begin
          st_o.phase = ifr_pkg::PH_ADDR;
        end else begin
          st_o.phase = ifr_pkg::PH_HUNT;
        end
      end
      ifr_pkg::PH_BCC1: begin
        if (byte_i == bcc1) begin
          st_o.phase    = ifr_pkg::PH_INFO;
          st_o.check    = '0;
          st_o.held     = '0;
          st_o.held_vld = 1'b0;
          st_o.esc_pend = 1'b0;
        end else if (byte_i == cfg_i.flag) begin
          st_o.phase = ifr_pkg::PH_ADDR;
        end else begin
          st_o.phase = ifr_pkg::PH_HUNT;
        end
      end
      ifr_pkg::PH_INFO: begin
        if (byte_i == cfg_i.flag) begin
          st_o.phase    = ifr_pkg::PH_HUNT;
          st_o.esc_pend = 1'b0;
          st_o.held_vld = 1'b0;
          if (chk_ok && seq_ok) st_o.exp_seq = ~st_i.exp_seq;
        end else if (take) begin
          st_o.esc_pend = 1'b0;
          if (st_i.held_vld) st_o.check = st_i.check ^ st_i.held;
          st_o.held     = data;
          st_o.held_vld = 1'b1;
        end else begin
          st_o.esc_pend = 1'b1;
        end
      end
      default: begin
        st_o.phase = ifr_pkg::PH_HUNT;
      end
    endcase
  end

  always_comb begin
    res_vld_o = 1'b0;
    res_o     = '{kind: ifr_pkg::KIND_PAYLOAD, data: '0, verdict: ifr_pkg::VERDICT_NONE};
    if (st_i.phase == ifr_pkg::PH_INFO) begin
      if (byte_i == cfg_i.flag) begin
        res_vld_o  = 1'b1;
        res_o.kind = ifr_pkg::KIND_VERDICT;
        if (!chk_ok) begin
          res_o.data                     = ifr_pkg::CTRL_REJ;
          res_o.data[ifr_pkg::REPLY_BIT] = nseq;
          res_o.verdict                  = ifr_pkg::VERDICT_REJECT;
        end else if (!seq_ok) begin
          res_o.data                     = ifr_pkg::CTRL_RR;
          res_o.data[ifr_pkg::REPLY_BIT] = nseq;
          res_o.verdict                  = ifr_pkg::VERDICT_DUP;
        end else begin
          res_o.data                     = ifr_pkg::CTRL_RR;
          res_o.data[ifr_pkg::REPLY_BIT] = ~st_i.exp_seq;
          res_o.verdict                  = ifr_pkg::VERDICT_ACCEPT;
        end
      end else if (take && st_i.held_vld) begin
        res_vld_o  = 1'b1;
        res_o.data = st_i.held;
      end
    end
  end

endmodule

/* hdl/info_frame_receiver_top.sv */
// After its byte is accepted, a result goes through the input register, then the result register.
// Throughput: one byte per cycle; a held byte stalls while a finished result waits downstream.
// A byte that ends nothing (hunting, header, escape, first info byte) yields no result.
// Reset: asynchronous, active low; parser returns to flag hunting, expected sequence 0,
// registers return to flag 0x7E, escape 0x7D, address 0x03.
module info_frame_receiver_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ifr_byte_if.sink                      rx_i,
  ifr_result_if.source                  res_o,
  input  logic                          cfg_we_i,
  input  logic [ifr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ifr_pkg::BYTE_W-1:0]    cfg_data_i
);

  ifr_pkg::cfg_t              cfg_q;
  ifr_pkg::state_t            st_q;
  ifr_pkg::state_t            st_d;
  logic                       in_vld_q;
  logic [ifr_pkg::BYTE_W-1:0] in_byte_q;
  logic                       out_vld_q;
  ifr_pkg::result_t           out_q;
  ifr_pkg::result_t           res_d;
  logic                       res_vld_d;
  logic                       adv;

  assign adv      = in_vld_q && (!out_vld_q || res_o.ready);
  assign rx_i.ready = !in_vld_q || adv;

  ifr_parser u_parser (
    .cfg_i     (cfg_q),
    .st_i      (st_q),
    .byte_i    (in_byte_q),
    .st_o      (st_d),
    .res_vld_o (res_vld_d),
    .res_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flag    <= ifr_pkg::FLAG_RESET;
      cfg_q.escape  <= ifr_pkg::ESCAPE_RESET;
      cfg_q.address <= ifr_pkg::ADDRESS_RESET;
    end else if (cfg_we_i) begin
      case (ifr_pkg::cfg_reg_e'(cfg_idx_i))
        ifr_pkg::CFG_FLAG:    cfg_q.flag    <= cfg_data_i;
        ifr_pkg::CFG_ESCAPE:  cfg_q.escape  <= cfg_data_i;
        ifr_pkg::CFG_ADDRESS: cfg_q.address <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{phase: ifr_pkg::PH_HUNT, exp_seq: 1'b0, frame_seq: 1'b0,
                check: '0, held: '0, held_vld: 1'b0, esc_pend: 1'b0};
    end else if (adv) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (rx_i.ready) in_vld_q <= rx_i.valid;
      if (adv) out_vld_q <= res_vld_d;
      else if (res_o.ready) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) in_byte_q <= rx_i.rx_byte;
    if (adv && res_vld_d) out_q <= res_d;
  end

  assign res_o.valid    = out_vld_q;
  assign res_o.out_kind = out_q.kind;
  assign res_o.out_byte = out_q.data;
  assign res_o.verdict  = out_q.verdict;

endmodule

/* hdl/ifr_checker.sv */
module ifr_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       res_valid_i,
  input logic                       res_ready_i,
  input logic                       res_kind_i,
  input logic [ifr_pkg::BYTE_W-1:0] res_byte_i,
  input logic [1:0]                 res_verdict_i
);

  logic is_verdict;
  logic is_reject;

  assign is_verdict = res_kind_i == ifr_pkg::KIND_VERDICT;
  assign is_reject  = res_verdict_i == ifr_pkg::VERDICT_REJECT;

  a_payload_no_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !is_verdict |-> res_verdict_i == ifr_pkg::VERDICT_NONE)
    else $error("payload item carries a verdict");

  a_verdict_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && is_verdict |-> res_verdict_i != ifr_pkg::VERDICT_NONE)
    else $error("verdict item without verdict code");

  a_reply_ctrl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && is_verdict |->
      (is_reject && res_byte_i[ifr_pkg::REPLY_BIT-1:0] == ifr_pkg::CTRL_REJ[ifr_pkg::REPLY_BIT-1:0])
      || (!is_reject
          && res_byte_i[ifr_pkg::REPLY_BIT-1:0] == ifr_pkg::CTRL_RR[ifr_pkg::REPLY_BIT-1:0]))
    else $error("reply control byte does not match verdict");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_kind_i)
      && $stable(res_byte_i) && $stable(res_verdict_i))
    else $error("stalled item changed");

endmodule

bind info_frame_receiver_top ifr_checker u_ifr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .res_kind_i    (res_o.out_kind),
  .res_byte_i    (res_o.out_byte),
  .res_verdict_i (res_o.verdict)
);
